[hw/rtl/hfe_pkg.sv]
// Shared types and constants for the Haar feature evaluator.
package hfe_pkg;
  localparam int EntryW = 18;
  localparam int CoordW = 5;
  localparam int TypeW = 3;
  localparam int NormW = 24;
  localparam int ValueW = 47;
  localparam int SumW = 24;
  localparam int MagW = SumW + NormW;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [TypeW-1:0] FT_EDGE_V = 3'd0;
  localparam logic [TypeW-1:0] FT_EDGE_H = 3'd1;
  localparam logic [TypeW-1:0] FT_LINE_V = 3'd2;
  localparam logic [TypeW-1:0] FT_LINE_H = 3'd3;
  localparam logic [TypeW-1:0] FT_DIAG = 3'd4;

  typedef struct packed {
    logic [TypeW-1:0] ftype;
    logic [CoordW-1:0] x1, x2, x3, x4;
    logic [CoordW-1:0] y1, y2, y3, y4;
  } eval_t;

  // Sum job from front to divider.
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic zero;
  } job_t;
endpackage

[hw/rtl/hfe_front.sv]
// Front end: corner store, corner reads (three per cycle) and weighted sum.
module hfe_front #(
  parameter int WINDOW_ROWS = 24,
  parameter int WINDOW_COLS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_command,
  input  logic [hfe_pkg::EntryW-1:0] in_entry_value,
  input  hfe_pkg::eval_t in_eval,
  output logic job_valid,
  output hfe_pkg::job_t job,
  input  logic job_stall
);
  localparam int Stride = WINDOW_COLS + 1;
  localparam int Depth = (WINDOW_ROWS + 1) * Stride;
  localparam int AddrW = $clog2(Depth);
  localparam int SW = hfe_pkg::SumW;

  // Two copies written together: ports 0 and 1 read one copy, port 2 the other.
  logic [hfe_pkg::EntryW-1:0] mem_a [Depth];
  logic [hfe_pkg::EntryW-1:0] mem_b [Depth];
  logic [hfe_pkg::EntryW-1:0] rd_r [3];
  logic [AddrW-1:0] ra [3];
  logic rok [3];
  logic rok_r [3];
  logic signed [3:0] wt [3];
  logic signed [3:0] wt_r [3];

  hfe_pkg::eval_t ev_r;
  logic busy_r;
  logic [1:0] ph_r;
  logic acc_live_r;  // read data of previous phase pending accumulation
  logic last_r;
  logic signed [SW-1:0] acc_r;
  logic out_v_r;
  hfe_pkg::job_t out_r;
  logic zero_r;

  logic accept;
  logic [4:0] cx [3];
  logic [4:0] cy [3];

  assign in_stall = busy_r || acc_live_r || (out_v_r && job_stall);
  assign accept = in_valid && !in_stall;
  assign job_valid = out_v_r;
  assign job = out_r;

  function automatic logic [AddrW-1:0] addr_of(input logic [4:0] x, input logic [4:0] y);
    logic [AddrW+6:0] a;
    a = (AddrW+7)'(x) * (AddrW+7)'(Stride) + (AddrW+7)'(y);
    return a[AddrW-1:0];
  endfunction

  // Corner schedule per phase: three (x, y, weight) triples.
  always_comb begin
    hfe_pkg::eval_t e;
    e = ev_r;
    for (int i = 0; i < 3; i++) begin
      cx[i] = e.x1; cy[i] = e.y1; wt[i] = 4'sd0;
    end
    case (e.ftype)
      hfe_pkg::FT_EDGE_V: begin
        case (ph_r)
          2'd0: begin
            cx[0]=e.x1; cy[0]=e.y3; wt[0]=4'sd1;
            cx[1]=e.x1; cy[1]=e.y1; wt[1]=-4'sd1;
            cx[2]=e.x3; cy[2]=e.y3; wt[2]=4'sd1;
          end
          2'd1: begin
            cx[0]=e.x3; cy[0]=e.y1; wt[0]=-4'sd1;
            cx[1]=e.x2; cy[1]=e.y1; wt[1]=4'sd2;
            cx[2]=e.x2; cy[2]=e.y3; wt[2]=-4'sd2;
          end
          default: ;
        endcase
      end
      hfe_pkg::FT_EDGE_H: begin
        case (ph_r)
          2'd0: begin
            cx[0]=e.x3; cy[0]=e.y1; wt[0]=4'sd1;
            cx[1]=e.x3; cy[1]=e.y3; wt[1]=4'sd1;
            cx[2]=e.x1; cy[2]=e.y1; wt[2]=-4'sd1;
          end
          2'd1: begin
            cx[0]=e.x1; cy[0]=e.y3; wt[0]=-4'sd1;
            cx[1]=e.x1; cy[1]=e.y2; wt[1]=4'sd2;
            cx[2]=e.x3; cy[2]=e.y2; wt[2]=-4'sd2;
          end
          default: ;
        endcase
      end
      hfe_pkg::FT_LINE_V: begin
        case (ph_r)
          2'd0: begin
            cx[0]=e.x1; cy[0]=e.y1; wt[0]=4'sd1;
            cx[1]=e.x1; cy[1]=e.y3; wt[1]=-4'sd1;
            cx[2]=e.x4; cy[2]=e.y3; wt[2]=4'sd1;
          end
          2'd1: begin
            cx[0]=e.x4; cy[0]=e.y1; wt[0]=-4'sd1;
            cx[1]=e.x2; cy[1]=e.y3; wt[1]=4'sd3;
            cx[2]=e.x2; cy[2]=e.y1; wt[2]=-4'sd3;
          end
          default: begin
            cx[0]=e.x3; cy[0]=e.y1; wt[0]=4'sd3;
            cx[1]=e.x3; cy[1]=e.y3; wt[1]=-4'sd3;
          end
        endcase
      end
      hfe_pkg::FT_LINE_H: begin
        case (ph_r)
          2'd0: begin
            cx[0]=e.x1; cy[0]=e.y1; wt[0]=4'sd1;
            cx[1]=e.x1; cy[1]=e.y4; wt[1]=-4'sd1;
            cx[2]=e.x3; cy[2]=e.y4; wt[2]=4'sd1;
          end
          2'd1: begin
            cx[0]=e.x3; cy[0]=e.y1; wt[0]=-4'sd1;
            cx[1]=e.x3; cy[1]=e.y2; wt[1]=4'sd3;
            cx[2]=e.x3; cy[2]=e.y3; wt[2]=-4'sd3;
          end
          default: begin
            cx[0]=e.x1; cy[0]=e.y3; wt[0]=4'sd3;
            cx[1]=e.x1; cy[1]=e.y2; wt[1]=-4'sd3;
          end
        endcase
      end
      hfe_pkg::FT_DIAG: begin
        case (ph_r)
          2'd0: begin
            cx[0]=e.x1; cy[0]=e.y1; wt[0]=4'sd1;
            cx[1]=e.x1; cy[1]=e.y3; wt[1]=4'sd1;
            cx[2]=e.x3; cy[2]=e.y1; wt[2]=4'sd1;
          end
          2'd1: begin
            cx[0]=e.x3; cy[0]=e.y3; wt[0]=4'sd1;
            cx[1]=e.x2; cy[1]=e.y1; wt[1]=-4'sd2;
            cx[2]=e.x2; cy[2]=e.y3; wt[2]=-4'sd2;
          end
          default: begin
            cx[0]=e.x1; cy[0]=e.y2; wt[0]=-4'sd2;
            cx[1]=e.x3; cy[1]=e.y2; wt[1]=-4'sd2;
            cx[2]=e.x2; cy[2]=e.y2; wt[2]=4'sd4;
          end
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      rok[i] = (32'(cx[i]) <= WINDOW_ROWS) && (32'(cy[i]) <= WINDOW_COLS);
      ra[i] = addr_of(cx[i], cy[i]);
    end
  end

  logic phase_last;
  assign phase_last = (ph_r == 2'd2) ||
                      ((ev_r.ftype == hfe_pkg::FT_EDGE_V || ev_r.ftype == hfe_pkg::FT_EDGE_H)
                       && ph_r == 2'd1) ||
                      (ev_r.ftype > hfe_pkg::FT_DIAG);

  // Store write into both copies and three read ports.
  always_ff @(posedge clk) begin
    if (accept && in_command == hfe_pkg::CMD_LOAD &&
        32'(in_eval.x1) <= WINDOW_ROWS && 32'(in_eval.y1) <= WINDOW_COLS) begin
      mem_a[addr_of(in_eval.x1, in_eval.y1)] <= in_entry_value;
      mem_b[addr_of(in_eval.x1, in_eval.y1)] <= in_entry_value;
    end
    rd_r[0] <= mem_a[ra[0]];
    rd_r[1] <= mem_a[ra[1]];
    rd_r[2] <= mem_b[ra[2]];
    for (int i = 0; i < 3; i++) begin
      rok_r[i] <= rok[i];
      wt_r[i] <= wt[i];
    end
  end

  logic signed [SW-1:0] term_sum;
  always_comb begin
    term_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (rok_r[i]) term_sum = term_sum + SW'(signed'({1'b0, rd_r[i]})) * SW'(wt_r[i]);
    end
  end

  logic signed [SW-1:0] acc_nxt;
  assign acc_nxt = acc_r + term_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= '0;
      acc_live_r <= 1'b0;
      last_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && !job_stall) out_v_r <= 1'b0;
      if (accept && in_command == hfe_pkg::CMD_EVAL) begin
        busy_r <= 1'b1;
        ph_r <= '0;
        ev_r <= in_eval;
        acc_r <= '0;
      end
      if (busy_r) begin
        acc_live_r <= 1'b1;
        last_r <= phase_last;
        zero_r <= ev_r.ftype > hfe_pkg::FT_DIAG;
        ph_r <= ph_r + 2'd1;
        if (phase_last) busy_r <= 1'b0;
      end else begin
        acc_live_r <= 1'b0;
      end
      if (acc_live_r) begin
        acc_r <= acc_nxt;
        if (last_r) begin
          out_v_r <= 1'b1;
          out_r.sum <= acc_nxt;
          out_r.zero <= zero_r;
        end
      end
    end
  end
endmodule

[hw/rtl/hfe_fifo.sv]
// Two-entry queue between front end and divider.
module hfe_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  hfe_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output hfe_pkg::job_t rd_data
);
  hfe_pkg::job_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = q_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[hw/rtl/hfe_divider.sv]
// Back end: restoring divider of |sum| << 24 by the normalizer, one bit per cycle.
module hfe_divider (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_stall,
  input  hfe_pkg::job_t job,
  input  logic [hfe_pkg::NormW-1:0] norm,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [hfe_pkg::ValueW-1:0] out_feature_value
);
  localparam int MW = hfe_pkg::MagW;
  localparam int NW = hfe_pkg::NormW;
  localparam int CW = $clog2(MW + 1);

  logic busy_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] q_r;
  logic [NW:0] rem_r;
  logic [NW-1:0] d_r;
  logic neg_r;
  logic ov_r;
  logic signed [hfe_pkg::ValueW-1:0] res_r;

  logic [NW:0] sh;
  logic [NW:0] diff;
  logic ge;
  logic [hfe_pkg::SumW-1:0] mag;
  logic [hfe_pkg::ValueW-1:0] quo;
  logic take;
  logic done;

  assign job_stall = busy_r || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_feature_value = res_r;
  assign mag = job.sum[hfe_pkg::SumW-1] ? -job.sum : job.sum;
  assign sh = {rem_r[NW-1:0], q_r[MW-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge = sh >= {1'b0, d_r};
  assign quo = {q_r[hfe_pkg::ValueW-2:0], ge};
  assign take = job_valid && !job_stall;
  assign done = busy_r && cnt_r == CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (take && job.zero) ov_r <= 1'b1;
      else if (done) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      if (take) begin
        if (job.zero) begin
          res_r <= '0;
        end else begin
          busy_r <= 1'b1;
          cnt_r <= CW'(MW);
          q_r <= {mag, {NW{1'b0}}};
          rem_r <= '0;
          d_r <= (norm == '0) ? NW'(1) : norm;
          neg_r <= job.sum[hfe_pkg::SumW-1];
        end
      end
      if (busy_r) begin
        rem_r <= ge ? diff : sh;
        q_r <= {q_r[MW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (done) begin
          busy_r <= 1'b0;
          res_r <= neg_r ? -$signed(quo) : $signed(quo);
        end
      end
    end
  end
endmodule

[hw/rtl/haar_feature_evaluator.sv]
// Haar-like feature evaluator top level: front end, job queue and divider.
// The block keeps a (WINDOW_ROWS+1) x (WINDOW_COLS+1) integral-image window in
// an internal memory held as two copies written together, giving one write port
// and three read ports. A load item (command 0) writes one entry; out-of-window
// loads are dropped. An evaluate item (command 1) reads its corners three per
// cycle, and the front end takes no new item until its weighted sum is formed.
// The weighted sum goes through a two-entry queue to a restoring divider that
// forms (|sum| << 24) / normalizer one quotient bit a cycle and takes no new
// job until the last is done, so sustained evaluate throughput is set by that
// divider; the queue lets the front end keep loading and reading while the
// divider works. The normalizer is latched per result at divider start; write
// it only while idle.
module haar_feature_evaluator #(
  parameter int WINDOW_ROWS = 24,
  parameter int WINDOW_COLS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [23:0] cfg_normalizer,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_command,
  input  logic [17:0] in_entry_value,
  input  logic [2:0] in_feature_type,
  input  logic [4:0] in_x1,
  input  logic [4:0] in_x2,
  input  logic [4:0] in_x3,
  input  logic [4:0] in_x4,
  input  logic [4:0] in_y1,
  input  logic [4:0] in_y2,
  input  logic [4:0] in_y3,
  input  logic [4:0] in_y4,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [46:0] out_feature_value
);
  logic [hfe_pkg::NormW-1:0] norm_r;
  hfe_pkg::eval_t ev;
  hfe_pkg::job_t fj, qj;
  logic fv, fs, qv, qs;

  // Hold the normalizer; reset value is 1.0 in Q16.8.
  always_ff @(posedge clk) begin
    if (!rst_n) norm_r <= 24'd256;
    else if (cfg_we) norm_r <= cfg_normalizer;
  end

  assign ev = '{ftype: in_feature_type, x1: in_x1, x2: in_x2, x3: in_x3, x4: in_x4,
                y1: in_y1, y2: in_y2, y3: in_y3, y4: in_y4};

  hfe_front #(.WINDOW_ROWS(WINDOW_ROWS), .WINDOW_COLS(WINDOW_COLS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_entry_value(in_entry_value), .in_eval(ev),
    .job_valid(fv), .job(fj), .job_stall(fs));

  hfe_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(fv), .wr_stall(fs), .wr_data(fj),
    .rd_valid(qv), .rd_stall(qs), .rd_data(qj));

  hfe_divider u_div (
    .clk(clk), .rst_n(rst_n), .job_valid(qv), .job_stall(qs), .job(qj),
    .norm(norm_r), .out_valid(out_valid), .out_stall(out_stall),
    .out_feature_value(out_feature_value));
endmodule

[test/feature_value_checker.sv]
`timescale 1ns / 1ps
// Checker for the Haar feature evaluator: mirrors the window, predicts and compares.
module feature_value_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [hfe_pkg::NormW-1:0] cfg_normalizer,
  input  logic in_valid,
  input  logic in_stall,
  input  logic in_command,
  input  logic [hfe_pkg::EntryW-1:0] in_entry_value,
  input  logic [hfe_pkg::TypeW-1:0] in_feature_type,
  input  logic [hfe_pkg::CoordW-1:0] in_x1, in_x2, in_x3, in_x4,
  input  logic [hfe_pkg::CoordW-1:0] in_y1, in_y2, in_y3, in_y4,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [hfe_pkg::ValueW-1:0] out_feature_value,
  output int fail_count,
  output int pending_count
);
  localparam int LastIdx = 24;

  logic [hfe_pkg::EntryW-1:0] window_mirror [0:LastIdx][0:LastIdx];
  logic [hfe_pkg::NormW-1:0] divisor_shadow;
  logic signed [hfe_pkg::ValueW-1:0] pending_values [$];

  function automatic longint corner(logic [hfe_pkg::CoordW-1:0] r,
                                    logic [hfe_pkg::CoordW-1:0] c);
    if (r > LastIdx || c > LastIdx) return 0;
    return longint'(window_mirror[r][c]);
  endfunction

  function automatic logic signed [hfe_pkg::ValueW-1:0] predict_feature(
      logic [hfe_pkg::TypeW-1:0] ft, logic [hfe_pkg::CoordW-1:0] a1, a2, a3, a4,
      logic [hfe_pkg::CoordW-1:0] b1, b2, b3, b4);
    longint s;
    logic [63:0] mag, quo, div;
    case (ft)
      hfe_pkg::FT_EDGE_V: s = corner(a1, b3) - corner(a1, b1) + corner(a3, b3)
                   - corner(a3, b1) + 2 * (corner(a2, b1) - corner(a2, b3));
      hfe_pkg::FT_EDGE_H: s = corner(a3, b1) + corner(a3, b3) - corner(a1, b1)
                   - corner(a1, b3) + 2 * (corner(a1, b2) - corner(a3, b2));
      hfe_pkg::FT_LINE_V: s = corner(a1, b1) - corner(a1, b3) + corner(a4, b3)
                   - corner(a4, b1)
                   + 3 * (corner(a2, b3) - corner(a2, b1) + corner(a3, b1)
                   - corner(a3, b3));
      hfe_pkg::FT_LINE_H: s = corner(a1, b1) - corner(a1, b4) + corner(a3, b4)
                   - corner(a3, b1)
                   + 3 * (corner(a3, b2) - corner(a3, b3) + corner(a1, b3)
                   - corner(a1, b2));
      hfe_pkg::FT_DIAG: s = corner(a1, b1) + corner(a1, b3) + corner(a3, b1)
                 + corner(a3, b3)
                 - 2 * (corner(a2, b1) + corner(a2, b3) + corner(a1, b2) + corner(a3, b2))
                 + 4 * corner(a2, b2);
      default: return '0;
    endcase
    // zero divisor behaves as the smallest nonzero one
    div = (divisor_shadow == 0) ? 64'd1 : 64'(divisor_shadow);
    mag = (s < 0) ? 64'(-s) : 64'(s);
    quo = (mag << 24) / div;
    if (s < 0) quo = -quo;
    return quo[hfe_pkg::ValueW-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      divisor_shadow <= 24'd256;
      pending_values.delete();
      pending_count <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) divisor_shadow <= cfg_normalizer;
      // compare results before queueing this edge's item
      if (out_valid && !out_stall) begin
        if (pending_values.size() == 0) begin
          $display("%0t: feature_value expected none actual %0d", $time, out_feature_value);
          fail_count <= fail_count + 1;
        end else begin
          if (out_feature_value !== pending_values[0]) begin
            $display("%0t: feature_value expected %0d actual %0d", $time,
                     pending_values[0], out_feature_value);
            fail_count <= fail_count + 1;
          end
          void'(pending_values.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        if (in_command == hfe_pkg::CMD_EVAL) begin
          pending_values.push_back(predict_feature(in_feature_type, in_x1, in_x2, in_x3,
                                                   in_x4, in_y1, in_y2, in_y3, in_y4));
        end else if (in_x1 <= LastIdx && in_y1 <= LastIdx) begin
          window_mirror[in_x1][in_y1] <= in_entry_value;
        end
      end
      pending_count <= pending_values.size();
    end
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the Haar feature evaluator: stimulus, stall patterns and verdict.
module tb_top;
  localparam int LastIdx = 24;
  localparam int CycleLimit = 600000;
  localparam int RandomItems = 650;
  localparam int DrainCycles = 120;

  typedef struct {
    logic cmd;
    logic [hfe_pkg::EntryW-1:0] entry;
    logic [hfe_pkg::TypeW-1:0] ft;
    logic [hfe_pkg::CoordW-1:0] x [4];
    logic [hfe_pkg::CoordW-1:0] y [4];
  } hfe_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hfe_pkg::NormW-1:0] cfg_normalizer;
  logic in_valid, in_stall, in_command;
  logic [hfe_pkg::EntryW-1:0] in_entry_value;
  logic [hfe_pkg::TypeW-1:0] in_feature_type;
  logic [hfe_pkg::CoordW-1:0] in_x1, in_x2, in_x3, in_x4, in_y1, in_y2, in_y3, in_y4;
  logic out_valid, out_stall;
  logic signed [hfe_pkg::ValueW-1:0] out_feature_value;
  int fail_count, pending_count;
  int cycle_count;
  int items_sent;
  bit quiet_sender;
  bit written [0:LastIdx][0:LastIdx];

  haar_feature_evaluator dut (
    .clk, .rst_n, .cfg_we, .cfg_normalizer,
    .in_valid, .in_stall, .in_command, .in_entry_value, .in_feature_type,
    .in_x1, .in_x2, .in_x3, .in_x4, .in_y1, .in_y2, .in_y3, .in_y4,
    .out_valid, .out_stall, .out_feature_value
  );

  feature_value_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_normalizer,
    .in_valid, .in_stall, .in_command, .in_entry_value, .in_feature_type,
    .in_x1, .in_x2, .in_x3, .in_x4, .in_y1, .in_y2, .in_y3, .in_y4,
    .out_valid, .out_stall, .out_feature_value,
    .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stop a hung run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long quiet window and one long hold-off
  // so the job queue fills and the front end has to stall its input.
  initial begin
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (cycle_count == 4000) hold_left = 500;
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (cycle_count > 15000 && cycle_count < 22000) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 17);
      end
    end
  end

  // Rows and columns that a feature type reads; every known type reads a full grid, unknown types none.
  task automatic corner_grid(input hfe_item_t it,
                             output logic [hfe_pkg::CoordW-1:0] rows [4],
                             output int nr, output logic [hfe_pkg::CoordW-1:0] cols [4],
                             output int nc);
    rows = it.x;
    cols = it.y;
    nr = 0;
    nc = 0;
    case (it.ft)
      hfe_pkg::FT_EDGE_V: begin nr = 3; nc = 2; cols[1] = it.y[2]; end
      hfe_pkg::FT_EDGE_H: begin nr = 2; nc = 3; rows[1] = it.x[2]; end
      hfe_pkg::FT_LINE_V: begin nr = 4; nc = 2; cols[1] = it.y[2]; end
      hfe_pkg::FT_LINE_H: begin nr = 2; nc = 4; rows[1] = it.x[2]; end
      hfe_pkg::FT_DIAG: begin nr = 3; nc = 3; end
      default: ;
    endcase
  endtask

  // Find a corner that the item would read before it was ever loaded.
  task automatic find_unloaded(input hfe_item_t it, output bit missing,
                               output logic [hfe_pkg::CoordW-1:0] r,
                               output logic [hfe_pkg::CoordW-1:0] c);
    logic [hfe_pkg::CoordW-1:0] rows [4];
    logic [hfe_pkg::CoordW-1:0] cols [4];
    int nr, nc;
    missing = 1'b0;
    r = '0;
    c = '0;
    corner_grid(it, rows, nr, cols, nc);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        if (!missing && rows[i] <= LastIdx && cols[j] <= LastIdx &&
            !written[rows[i]][cols[j]]) begin
          missing = 1'b1;
          r = rows[i];
          c = cols[j];
        end
      end
    end
  endtask

  // Drive one item at the falling edge and hold it until accepted.
  task automatic send_item(input hfe_item_t it, input bit allow_gaps);
    while (allow_gaps && !quiet_sender && $urandom_range(0, 99) < 17) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_command = it.cmd;
    in_entry_value = it.entry;
    in_feature_type = it.ft;
    {in_x1, in_x2, in_x3, in_x4} = {it.x[0], it.x[1], it.x[2], it.x[3]};
    {in_y1, in_y2, in_y3, in_y4} = {it.y[0], it.y[1], it.y[2], it.y[3]};
    do @(posedge clk); while (in_stall);
    if (it.cmd == hfe_pkg::CMD_LOAD && it.x[0] <= LastIdx && it.y[0] <= LastIdx)
      written[it.x[0]][it.y[0]] = 1'b1;
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Idle the input, then wait until every result is back and loads have settled.
  task automatic wait_idle();
    drop_valid();
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_normalizer(input logic [hfe_pkg::NormW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_normalizer = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic hfe_item_t load_item(logic [hfe_pkg::CoordW-1:0] r,
                                          logic [hfe_pkg::CoordW-1:0] c,
                                          logic [hfe_pkg::EntryW-1:0] value);
    hfe_item_t it;
    it.cmd = hfe_pkg::CMD_LOAD;
    it.entry = value;
    it.ft = hfe_pkg::TypeW'($urandom);
    for (int k = 0; k < 4; k++) begin
      it.x[k] = hfe_pkg::CoordW'($urandom);
      it.y[k] = hfe_pkg::CoordW'($urandom);
    end
    it.x[0] = r;
    it.y[0] = c;
    return it;
  endfunction

  function automatic hfe_item_t eval_item(logic [hfe_pkg::TypeW-1:0] ft,
                                          logic [hfe_pkg::CoordW-1:0] a1, a2,
                                          a3, a4, b1, b2, b3, b4);
    hfe_item_t it;
    it.cmd = hfe_pkg::CMD_EVAL;
    it.entry = hfe_pkg::EntryW'($urandom);
    it.ft = ft;
    it.x = '{a1, a2, a3, a4};
    it.y = '{b1, b2, b3, b4};
    return it;
  endfunction

  function automatic logic [hfe_pkg::CoordW-1:0] rand_coord();
    // mostly inside the window, sometimes past its edge
    if ($urandom_range(0, 99) < 88) return hfe_pkg::CoordW'($urandom_range(0, LastIdx));
    return hfe_pkg::CoordW'($urandom_range(LastIdx + 1, 31));
  endfunction

  function automatic logic [hfe_pkg::EntryW-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return hfe_pkg::EntryW'($urandom);
      default: return hfe_pkg::EntryW'($urandom_range(0, 146880));
    endcase
  endfunction

  task automatic run_random(input int count);
    hfe_item_t it;
    bit missing;
    logic [hfe_pkg::CoordW-1:0] r, c;
    for (int n = 0; n < count; n++) begin
      // hold the sender quiet for a long run of items
      quiet_sender = (items_sent >= 300 && items_sent < 420);
      if ($urandom_range(0, 99) < 35) begin
        it = load_item(rand_coord(), rand_coord(), rand_entry());
      end else begin
        it = eval_item(($urandom_range(0, 99) < 8) ? hfe_pkg::TypeW'($urandom_range(5, 7))
                       : hfe_pkg::TypeW'($urandom_range(0, 4)),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
        find_unloaded(it, missing, r, c);
        // never read an entry that was not loaded: load it instead
        if (missing) it = load_item(r, c, rand_entry());
      end
      send_item(it, 1'b1);
      // once, let every result drain before going on
      if (items_sent == 250) begin
        drop_valid();
        while (pending_count != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [hfe_pkg::CoordW-1:0] grid [3];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_normalizer = '0;
    in_valid = 1'b0;
    in_command = hfe_pkg::CMD_LOAD;
    in_entry_value = '0;
    in_feature_type = '0;
    {in_x1, in_x2, in_x3, in_x4, in_y1, in_y2, in_y3, in_y4} = '0;
    items_sent = 0;
    quiet_sender = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: load a coarse grid with extreme values, drop out-of-window
    // loads, then evaluate every type, unknown types and off-window corners.
    grid = '{5'd0, 5'd12, 5'd24};
    foreach (grid[i]) begin
      foreach (grid[j]) begin
        send_item(load_item(grid[i], grid[j],
                            (i == 2 && j == 2) ? '1 : (i == 0 && j == 0) ? '0 :
                            (i == 1 && j == 1) ? hfe_pkg::EntryW'(146880)
                            : hfe_pkg::EntryW'($urandom_range(0, 146880))), 1'b0);
      end
    end
    send_item(load_item(5'd31, 5'd3, '1), 1'b0);
    send_item(load_item(5'd3, 5'd25, '1), 1'b0);
    send_item(eval_item(hfe_pkg::FT_EDGE_V, 0, 12, 24, 24, 0, 12, 24, 24), 1'b0);
    send_item(eval_item(hfe_pkg::FT_EDGE_H, 0, 12, 24, 24, 0, 12, 24, 24), 1'b0);
    send_item(eval_item(hfe_pkg::FT_LINE_V, 0, 12, 24, 12, 0, 12, 24, 24), 1'b0);
    send_item(eval_item(hfe_pkg::FT_LINE_H, 0, 12, 24, 24, 0, 12, 24, 12), 1'b0);
    send_item(eval_item(hfe_pkg::FT_DIAG, 0, 12, 24, 24, 0, 12, 24, 24), 1'b0);
    send_item(eval_item(hfe_pkg::FT_DIAG, 24, 0, 12, 31, 24, 12, 0, 31), 1'b0);
    send_item(eval_item(hfe_pkg::FT_DIAG, 31, 31, 25, 31, 31, 25, 31, 31), 1'b0);
    send_item(eval_item(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_item(eval_item(3'd7, 31, 31, 31, 31, 31, 31, 31, 31), 1'b0);

    // Random phases across normalizer settings, extremes included.
    run_random(RandomItems / 5);
    write_normalizer(24'd1);
    run_random(RandomItems / 5);
    write_normalizer(24'hFFFFFF);
    run_random(RandomItems / 5);
    write_normalizer(24'd0);
    run_random(RandomItems / 5);
    write_normalizer(hfe_pkg::NormW'($urandom_range(2, 24'hFFFFFE)));
    run_random(RandomItems / 5);

    drop_valid();
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
